@@ rtl/core/utf8d_pkg.sv @@
// utf8d_pkg: types and byte-class constants for the UTF-8 stream decoder.
// Used by utf8d_decode and utf8_stream_decoder; depends on nothing.
package utf8d_pkg;

  localparam int CpWidth = 21;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] ContMask   = 8'hC0;
  localparam logic [7:0] ContCode   = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Code  = 8'hC0;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Code  = 8'hE0;
  localparam logic [7:0] Lead4Mask  = 8'hF8;
  localparam logic [7:0] Lead4Code  = 8'hF0;
  localparam logic [7:0] ContBits   = 8'h3F;
  localparam logic [7:0] Lead2Bits  = 8'h1F;
  localparam logic [7:0] Lead3Bits  = 8'h0F;
  localparam logic [7:0] Lead4Bits  = 8'h07;

  typedef struct packed {
    logic [1:0]         bytes_expected;
    logic [1:0]         bytes_buffered;
    logic [CpWidth-1:0] partial_code;
  } state_t;

  // Results of one byte: count-1 leading errors, then the final result.
  typedef struct packed {
    logic [2:0]         count;
    logic [CpWidth-1:0] final_cp;
    logic               final_err;
  } bundle_t;

endpackage

@@ rtl/core/utf8d_decode.sv @@
// utf8d_decode: combinational decode of one byte against the open sequence.
// Gives the result bundle and the next sequence state; uses utf8d_pkg.
module utf8d_decode (
  input  logic [7:0]        data_byte,
  input  utf8d_pkg::state_t state,
  output utf8d_pkg::state_t state_next,
  output utf8d_pkg::bundle_t bundle
);
  import utf8d_pkg::*;

  logic [2:0]         flush_count;
  logic [1:0]         buffered_inc;
  logic [CpWidth-1:0] cont_code;
  logic               start_result;
  logic [CpWidth-1:0] start_cp;
  logic               start_err;
  state_t             start_state;

  always_comb begin
    flush_count  = (state.bytes_buffered >= 2'd2) ? 3'd3 : {1'b0, state.bytes_buffered} + 3'd1;
    buffered_inc = state.bytes_buffered + 2'd1;
    cont_code    = {state.partial_code[CpWidth-7:0], data_byte[5:0] & ContBits[5:0]};

    start_state  = '0;
    start_result = 1'b1;
    start_cp     = '0;
    start_err    = 1'b0;
    if (data_byte < AsciiLimit) begin
      start_cp = CpWidth'(data_byte);
    end else if ((data_byte & Lead2Mask) == Lead2Code) begin
      start_result = 1'b0;
      start_state.bytes_expected = 2'd1;
      start_state.partial_code   = CpWidth'(data_byte & Lead2Bits);
    end else if ((data_byte & Lead3Mask) == Lead3Code) begin
      start_result = 1'b0;
      start_state.bytes_expected = 2'd2;
      start_state.partial_code   = CpWidth'(data_byte & Lead3Bits);
    end else if ((data_byte & Lead4Mask) == Lead4Code) begin
      start_result = 1'b0;
      start_state.bytes_expected = 2'd3;
      start_state.partial_code   = CpWidth'(data_byte & Lead4Bits);
    end else begin
      start_err = 1'b1;
    end

    state_next       = state;
    bundle.count     = 3'd0;
    bundle.final_cp  = '0;
    bundle.final_err = 1'b1;

    if (data_byte == 8'd0) begin
      state_next = '0;
      if (state.bytes_expected != 2'd0) begin
        bundle.count = flush_count;
      end
    end else if (state.bytes_expected != 2'd0) begin
      if ((data_byte & ContMask) == ContCode) begin
        state_next.partial_code   = cont_code;
        state_next.bytes_buffered = buffered_inc;
        if (buffered_inc >= state.bytes_expected) begin
          state_next       = '0;
          bundle.count     = 3'd1;
          bundle.final_cp  = cont_code;
          bundle.final_err = 1'b0;
        end
      end else begin
        state_next   = start_state;
        bundle.count = flush_count + {2'b00, start_result};
        if (start_result) begin
          bundle.final_cp  = start_cp;
          bundle.final_err = start_err;
        end
      end
    end else begin
      state_next       = start_state;
      bundle.count     = {2'b00, start_result};
      bundle.final_cp  = start_cp;
      bundle.final_err = start_err;
    end
  end

endmodule

@@ rtl/core/utf8_stream_decoder.sv @@
// utf8_stream_decoder: streaming UTF-8 decoder, top level.
// Input byte register, utf8d_decode, result register; uses utf8d_pkg.
//
// Takes one byte per cycle when not stalled and gives code points of up to 21
// bits, with error beats for bytes that cannot be decoded. A byte that causes
// n results holds the result register until all n are taken (n is 0 to 4; a
// flush of an interrupted sequence gives up to three error beats before the
// byte itself is decoded); a byte with one result or none passes at one per
// cycle unless stalled. The result register, which hands out one beat per
// cycle unless stalled, sets the rate. One byte waits in the input register
// while results are still going out, so a new byte is taken while a finished
// result is stalled. A zero byte ends the text and gives no beat of its own.
module utf8_stream_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [utf8d_pkg::CpWidth-1:0] code_point,
  output logic                        is_error,
  output logic                        last_of_run
);
  import utf8d_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;

  state_t  state;
  state_t  state_next;
  bundle_t bundle_next;

  logic [2:0]         remaining;
  logic [CpWidth-1:0] final_cp;
  logic               final_err;

  logic out_take;
  logic advance;

  assign out_take = out_valid && !out_stall;
  assign advance  = in_full && (remaining == 3'd0 || (remaining == 3'd1 && out_take));
  assign in_stall = in_full && !advance;

  utf8d_decode u_decode (
    .data_byte  (in_byte),
    .state      (state),
    .state_next (state_next),
    .bundle     (bundle_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      state     <= '0;
      remaining <= 3'd0;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        state     <= state_next;
        remaining <= bundle_next.count;
      end else if (out_take) begin
        remaining <= remaining - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= data_byte;
    end
    if (advance) begin
      final_cp  <= bundle_next.final_cp;
      final_err <= bundle_next.final_err;
    end
  end

  assign out_valid   = remaining != 3'd0;
  assign last_of_run = remaining == 3'd1;
  assign code_point  = last_of_run ? final_cp : '0;
  assign is_error    = last_of_run ? final_err : 1'b1;

endmodule

@@ bench/tb_utf8_stream_decoder.sv @@
// tb_utf8_stream_decoder: self-checking bench for the UTF-8 stream decoder.
// Walks a directed byte table, then random text, and predicts every beat in-bench.
// Depends on utf8d_pkg and utf8_stream_decoder.
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int DirN        = 26;
  localparam int RandItems   = 434;
  localparam int CalmItems   = 90;
  localparam int PhaseItems  = 90;
  localparam int PressAt     = DirN + 20;
  localparam int HoldCycles  = 64;
  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 16;
  localparam int MaxReports  = 10;

  typedef enum int {PH_CALM, PH_SEND_GAP, PH_RECV_STALL, PH_BOTH} phase_t;

  typedef struct packed {
    logic [CpWidth-1:0] cp;
    logic               err;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [7:0]         b;
    logic               known;
    logic [CpWidth-1:0] cp;
    logic               err;
  } row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic [7:0]         data_byte = 8'h00;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [CpWidth-1:0] code_point;
  logic               is_error;
  logic               last_of_run;

  row_t  directed_rows [0:DirN-1];
  row_t  stim_q [$];
  beat_t expected_q [$];

  logic [1:0]         dec_need = '0;
  logic [1:0]         dec_have = '0;
  logic [CpWidth-1:0] dec_acc  = '0;

  int next_item      = 0;
  int cur_item       = 0;
  int accepted_items = 0;
  int hold_left      = 0;
  bit held           = 1'b0;
  int quiet_cycles   = 0;
  int failures       = 0;
  int beats_seen     = 0;

  utf8_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .is_error    (is_error),
    .last_of_run (last_of_run)
  );

  always #4 clk = ~clk;

  function automatic void emit(logic [CpWidth-1:0] cp, logic err);
    expected_q.push_back({cp, err, 1'b0});
  endfunction

  function automatic int start_char(logic [7:0] b);
    if (b < AsciiLimit) begin
      emit(CpWidth'(b), 1'b0);
      return 1;
    end
    if ((b & Lead2Mask) == Lead2Code) begin
      dec_need = 2'd1;
      dec_acc  = CpWidth'(b & Lead2Bits);
    end else if ((b & Lead3Mask) == Lead3Code) begin
      dec_need = 2'd2;
      dec_acc  = CpWidth'(b & Lead3Bits);
    end else if ((b & Lead4Mask) == Lead4Code) begin
      dec_need = 2'd3;
      dec_acc  = CpWidth'(b & Lead4Bits);
    end else begin
      emit('0, 1'b1);
      return 1;
    end
    dec_have = 2'd0;
    return 0;
  endfunction

  function automatic int flush_open();
    int n;
    n = 1 + dec_have;
    repeat (n) emit('0, 1'b1);
    dec_need = '0;
    dec_have = '0;
    dec_acc  = '0;
    return n;
  endfunction

  function automatic int decode_byte(logic [7:0] b);
    int    n;
    beat_t tail;
    n = 0;
    if (b == 8'h00) begin
      if (dec_need != 0) n = flush_open();
    end else if (dec_need != 0) begin
      if ((b & ContMask) == ContCode) begin
        dec_acc  = {dec_acc[CpWidth-7:0], b[5:0]};
        dec_have = dec_have + 2'd1;
        if (dec_have >= dec_need) begin
          emit(dec_acc, 1'b0);
          n = 1;
          dec_need = '0;
          dec_have = '0;
          dec_acc  = '0;
        end
      end else begin
        n = flush_open();
        n = n + start_char(b);
      end
    end else begin
      n = start_char(b);
    end
    if (n > 0) begin
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
    return n;
  endfunction

  function automatic phase_t phase_of(int idx);
    if (idx < DirN + CalmItems) return PH_CALM;
    return phase_t'((((idx - DirN - CalmItems) / PhaseItems) % 4 + 1) % 4);
  endfunction

  function automatic int send_gap_pct(int idx);
    case (phase_of(idx))
      PH_SEND_GAP: return 48;
      PH_BOTH:     return 23;
      default:     return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(int idx);
    case (phase_of(idx))
      PH_RECV_STALL: return 48;
      PH_BOTH:       return 23;
      default:       return 0;
    endcase
  endfunction

  function automatic void push_byte(logic [7:0] b);
    stim_q.push_back({b, 1'b0, {CpWidth{1'b0}}, 1'b0});
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  task automatic build_stimulus();
    int         kind;
    int         len;
    int         keep;
    logic [7:0] lead;
    directed_rows = '{
      {8'h00, 1'b0, 21'h0,  1'b0},
      {8'h01, 1'b1, 21'h01, 1'b0},
      {8'h7F, 1'b1, 21'h7F, 1'b0},
      {8'h80, 1'b1, 21'h0,  1'b1},
      {8'hBF, 1'b1, 21'h0,  1'b1},
      {8'hF8, 1'b1, 21'h0,  1'b1},
      {8'hFF, 1'b1, 21'h0,  1'b1},
      {8'hC2, 1'b0, 21'h0,  1'b0},
      {8'hA9, 1'b0, 21'h0,  1'b0},
      {8'hE2, 1'b0, 21'h0,  1'b0},
      {8'h82, 1'b0, 21'h0,  1'b0},
      {8'hAC, 1'b0, 21'h0,  1'b0},
      {8'hF7, 1'b0, 21'h0,  1'b0},
      {8'hBF, 1'b0, 21'h0,  1'b0},
      {8'hBF, 1'b0, 21'h0,  1'b0},
      {8'hBF, 1'b0, 21'h0,  1'b0},
      {8'hC0, 1'b0, 21'h0,  1'b0},
      {8'h80, 1'b0, 21'h0,  1'b0},
      {8'hF0, 1'b0, 21'h0,  1'b0},
      {8'h80, 1'b0, 21'h0,  1'b0},
      {8'h80, 1'b0, 21'h0,  1'b0},
      {8'h41, 1'b0, 21'h0,  1'b0},
      {8'hE0, 1'b0, 21'h0,  1'b0},
      {8'h80, 1'b0, 21'h0,  1'b0},
      {8'hF0, 1'b0, 21'h0,  1'b0},
      {8'h00, 1'b0, 21'h0,  1'b0}
    };
    for (int i = 0; i < DirN; i++) stim_q.push_back(directed_rows[i]);
    while (stim_q.size() < DirN + RandItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        push_byte(8'h00);
      end else if (kind < 20) begin
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 4);
        case (len)
          1:       lead = 8'($urandom_range(1, 127));
          2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
          3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
          default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        keep = (kind < 32 && len > 1) ? $urandom_range(0, len - 2) : len - 1;
        push_byte(lead);
        repeat (keep) push_byte(cont_byte());
      end
    end
  endtask

  always @(posedge clk) begin : send_bytes
    logic  fire;
    int    n;
    row_t  row;
    beat_t scrap;
    if (rst) begin
      in_valid       <= 1'b0;
      next_item      <= 0;
      accepted_items <= 0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        row = stim_q[cur_item];
        n = decode_byte(row.b);
        if (row.known) begin
          repeat (n) scrap = expected_q.pop_back();
          expected_q.push_back({row.cp, row.err, 1'b1});
        end
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || fire) begin
        if (next_item < stim_q.size() && $urandom_range(0, 99) >= send_gap_pct(next_item)) begin
          in_valid  <= 1'b1;
          data_byte <= stim_q[next_item].b;
          cur_item  <= next_item;
          next_item <= next_item + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      held      <= 1'b0;
    end else if (!held && accepted_items >= PressAt) begin
      held      <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      out_stall <= $urandom_range(0, 99) < recv_stall_pct(accepted_items);
    end
  end

  always @(posedge clk) begin : check_beats
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_seen = beats_seen + 1;
      if (expected_q.size() == 0) begin
        failures = failures + 1;
        if (failures <= MaxReports)
          $display("beat %0d unexpected: cp %h err %b last %b",
                   beats_seen, code_point, is_error, last_of_run);
      end else begin
        want = expected_q.pop_front();
        if (code_point !== want.cp || is_error !== want.err || last_of_run !== want.last) begin
          failures = failures + 1;
          if (failures <= MaxReports)
            $display("beat %0d: expected cp %h err %b last %b, got cp %h err %b last %b",
                     beats_seen, want.cp, want.err, want.last,
                     code_point, is_error, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while ((accepted_items < stim_q.size() || expected_q.size() != 0)
           && quiet_cycles < QuietLimit)
      @(posedge clk);
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d bytes taken, %0d beats pending",
               quiet_cycles, accepted_items, expected_q.size());
      failures = failures + 1;
    end else begin
      repeat (DrainCycles) @(posedge clk);
    end
    if (expected_q.size() != 0) failures = failures + 1;
    if (failures == 0)
      $display("PASS utf8_stream_decoder");
    else
      $display("FAIL utf8_stream_decoder");
    $finish;
  end

endmodule
